// ===== rtl/sphtess_pkg.sv =====
// ----------------------------------------------------------------------------
// sphtess_pkg
// Shared types, codes and tables of the UV-sphere tessellator.
// ----------------------------------------------------------------------------
package sphtess_pkg;

    // parameter defaults
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed field widths
    localparam int SEG_W = 9;   // segment count registers
    localparam int CNT_W = 10;  // row counter, holds rows + 1
    localparam int IDX_W = 16;  // vertex index
    localparam int RAD_W = 16;  // radius, Q8.8

    // record kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    // CORDIC gain preset, Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // effective grid and radius
    typedef struct packed {
        logic [SEG_W-1:0] cols;
        logic [SEG_W-1:0] rows;
        logic [RAD_W-1:0] radius;
    } t_geom;

    // one classified tick, front to back
    typedef struct packed {
        logic             marker;
        logic             has_vtx;
        logic [1:0]       ntri;
        logic [SEG_W-1:0] x;
        logic [CNT_W-1:0] y;
        logic [IDX_W-1:0] a0;
        logic [IDX_W-1:0] b0;
        logic [IDX_W-1:0] c0;
        logic [IDX_W-1:0] a1;
        logic [IDX_W-1:0] b1;
        logic [IDX_W-1:0] c1;
    } t_cmd;

    // one result record
    typedef struct packed {
        logic [1:0]          kind;
        logic signed [16:0]  pos_x;
        logic signed [16:0]  pos_y;
        logic signed [16:0]  pos_z;
        logic signed [15:0]  norm_x;
        logic signed [15:0]  norm_y;
        logic signed [15:0]  norm_z;
        logic [IDX_W-1:0]    corner_a;
        logic [IDX_W-1:0]    corner_b;
        logic [IDX_W-1:0]    corner_c;
        logic                run_end;
    } t_rec;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:    atan_turn = 32'h20000000;
            5'd1:    atan_turn = 32'h12E4051E;
            5'd2:    atan_turn = 32'h09FB385B;
            5'd3:    atan_turn = 32'h051111D4;
            5'd4:    atan_turn = 32'h028B0D43;
            5'd5:    atan_turn = 32'h0145D7E1;
            5'd6:    atan_turn = 32'h00A2F61E;
            5'd7:    atan_turn = 32'h00517C55;
            5'd8:    atan_turn = 32'h0028BE53;
            5'd9:    atan_turn = 32'h00145F2F;
            5'd10:   atan_turn = 32'h000A2F98;
            5'd11:   atan_turn = 32'h000517CC;
            5'd12:   atan_turn = 32'h00028BE6;
            5'd13:   atan_turn = 32'h000145F3;
            5'd14:   atan_turn = 32'h0000A2F9;
            5'd15:   atan_turn = 32'h0000517C;
            5'd16:   atan_turn = 32'h000028BE;
            5'd17:   atan_turn = 32'h0000145F;
            5'd18:   atan_turn = 32'h00000A2F;
            5'd19:   atan_turn = 32'h00000517;
            5'd20:   atan_turn = 32'h0000028B;
            5'd21:   atan_turn = 32'h00000145;
            5'd22:   atan_turn = 32'h000000A2;
            5'd23:   atan_turn = 32'h00000051;
            default: atan_turn = 32'h00000000;
        endcase
    endfunction

    // Q2.30 to Q1.14, round half up, clamp to +-1.0
    function automatic logic signed [15:0] round_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
            round_q14 = 16'sd16384;
        else if (t < -34'sd16384)
            round_q14 = -16'sd16384;
        else
            round_q14 = t[15:0];
    endfunction

endpackage

// ===== rtl/sphtess_front.sv =====
// ----------------------------------------------------------------------------
// sphtess_front
// Grid sweep counters; classifies each tick and works out triangle corners.
// ----------------------------------------------------------------------------
module sphtess_front import sphtess_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_valid,
    input  logic  i_restart,
    output logic  o_ready,
    input  logic  i_full,
    output logic  o_push,
    output t_cmd  o_cmd
);

    logic [SEG_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             r_done, n_done;

    logic                   w_acc, w_end, w_wrap, w_top, w_bot, w_vtx;
    logic [CNT_W-1:0]       w_cw, w_rw, w_col1, w_row1, w_ym1;
    logic [SEG_W-1:0]       w_nx;
    logic [CNT_W+SEG_W-1:0] w_m;
    logic [IDX_W-1:0]       w_cur, w_up, w_xi, w_nxi, w_ci;
    logic [1:0]             w_ntri;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    // position in the grid
    always_comb begin
        w_cw   = {1'b0, i_geom.cols};
        w_rw   = {1'b0, i_geom.rows};
        w_end  = r_done || (r_row > w_rw) || ({1'b0, r_col} >= w_cw);
        w_col1 = {1'b0, r_col} + 1'b1;
        w_row1 = r_row + 1'b1;
        w_wrap = (w_col1 >= w_cw);
        w_nx   = w_wrap ? '0 : w_col1[SEG_W-1:0];
        w_top  = (r_row == '0);
        w_bot  = (r_row == w_rw);
        w_vtx  = !((w_top || w_bot) && (r_col != '0));
    end

    // row base indexes: cur = 1 + (y-1)*C, up = cur - C
    always_comb begin
        w_ym1 = r_row - 1'b1;
        w_m   = w_ym1 * i_geom.cols;
        w_ci  = {{(IDX_W-SEG_W){1'b0}}, i_geom.cols};
        w_cur = 16'd1 + w_m[IDX_W-1:0];
        w_up  = w_cur - w_ci;
        w_xi  = {{(IDX_W-SEG_W){1'b0}}, r_col};
        w_nxi = {{(IDX_W-SEG_W){1'b0}}, w_nx};
    end

    // command for the back end
    always_comb begin
        o_cmd         = '0;
        o_cmd.marker  = w_end;
        o_cmd.x       = r_col;
        o_cmd.y       = r_row;
        w_ntri        = 2'd0;
        if (!w_end) begin
            o_cmd.has_vtx = w_vtx;
            if (w_top) begin
                w_ntri = 2'd0;
            end else if (r_row == 10'd1) begin
                // top pole fan
                w_ntri   = 2'd1;
                o_cmd.a0 = '0;
                o_cmd.b0 = w_cur + w_xi;
                o_cmd.c0 = w_cur + w_nxi;
            end else if (w_bot) begin
                // bottom pole fan
                w_ntri   = 2'd1;
                o_cmd.a0 = w_up + w_xi;
                o_cmd.b0 = w_cur;
                o_cmd.c0 = w_up + w_nxi;
            end else begin
                // quad split in two
                w_ntri   = 2'd2;
                o_cmd.a0 = w_up + w_xi;
                o_cmd.b0 = w_cur + w_xi;
                o_cmd.c0 = w_up + w_nxi;
                o_cmd.a1 = w_up + w_nxi;
                o_cmd.b1 = w_cur + w_xi;
                o_cmd.c1 = w_cur + w_nxi;
            end
        end
        o_cmd.ntri = w_ntri;
    end

    assign o_push = w_acc && !i_restart && (w_end || w_vtx || (w_ntri != 2'd0));

    // sweep advance
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_done = r_done;
        if (w_acc) begin
            if (i_restart) begin
                n_col  = '0;
                n_row  = '0;
                n_done = 1'b0;
            end else if (w_end) begin
                n_done = 1'b1;
            end else if (w_wrap) begin
                n_col = '0;
                n_row = w_row1;
                if (w_row1 > w_rw) n_done = 1'b1;
            end else begin
                n_col = w_col1[SEG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_done <= n_done;
        end
    end

endmodule

// ===== rtl/sphtess_fifo.sv =====
// ----------------------------------------------------------------------------
// sphtess_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module sphtess_fifo import sphtess_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/sphtess_back.sv =====
// ----------------------------------------------------------------------------
// sphtess_back
// Vertex math (angle divider, CORDIC, scaling) and result sequencing.
// ----------------------------------------------------------------------------
module sphtess_back import sphtess_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_empty,
    output logic  o_pop,
    input  t_cmd  i_cmd,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rec  o_rec
);

    localparam int NW  = ANGLE_BITS + SEG_W + 1;  // dividend
    localparam int QW  = ANGLE_BITS + 1;          // quotient
    localparam int DCW = $clog2(QW + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CORD, S_MUL, S_EMIT} t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_phase;

    // divider
    logic [DCW-1:0]   r_dcnt;
    logic [SEG_W-1:0] r_rem, r_den;
    logic [QW-1:0]    r_dq;

    // CORDIC
    logic [4:0]         r_ci;
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic [1:0]         r_quad;

    // results
    logic signed [15:0] r_st, r_ct, r_sp, r_cp, r_n0, r_n2;
    logic signed [16:0] r_px, r_py, r_pz;
    logic [2:0]         r_k;
    logic               r_pend_v, r_tidx;
    logic               r_valid;
    t_rec               r_rec;

    logic [NW-1:0]      w_num_t, w_num_p;
    logic [SEG_W:0]     w_t, w_sub;
    logic               w_ge;
    logic [ANGLE_BITS-1:0] w_ang;
    logic signed [32:0] w_z0, w_atan;
    logic signed [33:0] w_xs, w_ys;
    logic signed [15:0] w_c, w_s, w_cs, w_sn;
    logic signed [16:0] w_ma, w_sat;
    logic signed [15:0] w_mb;
    logic signed [32:0] w_prod, w_rnd;
    logic               w_free, w_last;
    t_rec               w_rec;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign w_free  = !r_valid || i_ready;

    // angle dividends: x*2^A/C (queue head) and y*2^(A-1)/R, rounded
    always_comb begin
        w_num_t = (NW'(i_cmd.x) << ANGLE_BITS) + NW'(i_geom.cols >> 1);
        w_num_p = (NW'(r_cmd.y) << (ANGLE_BITS - 1)) + NW'(i_geom.rows >> 1);
        w_t     = {r_rem, r_dq[QW-1]};
        w_sub   = w_t - {1'b0, r_den};
        w_ge    = (w_t >= {1'b0, r_den});
    end

    // CORDIC datapath
    always_comb begin
        w_ang  = r_dq[ANGLE_BITS-1:0];
        w_z0   = 33'(w_ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        w_atan = {1'b0, atan_turn(r_ci)};
        w_xs   = r_cx >>> r_ci;
        w_ys   = r_cy >>> r_ci;
        w_c    = round_q14(r_cx);
        w_s    = round_q14(r_cy);
        case (r_quad)
            2'd0:    begin w_cs = w_c;  w_sn = w_s;  end
            2'd1:    begin w_cs = -w_s; w_sn = w_c;  end
            2'd2:    begin w_cs = -w_c; w_sn = -w_s; end
            default: begin w_cs = w_s;  w_sn = -w_c; end
        endcase
    end

    // shared multiplier: two normal products then three positions
    always_comb begin
        w_ma = (r_k < 3'd2) ? {r_sp[15], r_sp} : {1'b0, i_geom.radius};
        case (r_k)
            3'd0:    w_mb = r_st;
            3'd1:    w_mb = r_ct;
            3'd2:    w_mb = r_n0;
            3'd3:    w_mb = r_cp;
            default: w_mb = r_n2;
        endcase
        w_prod = w_ma * w_mb;
        w_rnd  = (w_prod + 33'sd8192) >>> 14;
        if (r_k < 3'd2) begin
            if (w_rnd > 33'sd16384)       w_sat = 17'sd16384;
            else if (w_rnd < -33'sd16384) w_sat = -17'sd16384;
            else                          w_sat = w_rnd[16:0];
        end else begin
            if (w_rnd > 33'sd65535)       w_sat = 17'sd65535;
            else if (w_rnd < -33'sd65535) w_sat = -17'sd65535;
            else                          w_sat = w_rnd[16:0];
        end
    end

    // next record
    always_comb begin
        w_rec  = '0;
        w_last = 1'b0;
        if (r_cmd.marker) begin
            w_rec.kind = KIND_DONE;
            w_last     = 1'b1;
        end else if (r_pend_v) begin
            w_rec.kind   = KIND_VERTEX;
            w_rec.pos_x  = r_px;
            w_rec.pos_y  = r_py;
            w_rec.pos_z  = r_pz;
            w_rec.norm_x = r_n0;
            w_rec.norm_y = r_cp;
            w_rec.norm_z = r_n2;
            w_last       = (r_cmd.ntri == 2'd0);
        end else begin
            w_rec.kind     = KIND_TRI;
            w_rec.corner_a = r_tidx ? r_cmd.a1 : r_cmd.a0;
            w_rec.corner_b = r_tidx ? r_cmd.b1 : r_cmd.b0;
            w_rec.corner_c = r_tidx ? r_cmd.c1 : r_cmd.c0;
            w_last         = ({1'b0, r_tidx} + 2'd1 == r_cmd.ntri);
        end
        w_rec.run_end = w_last;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_free) begin
                r_valid <= 1'b1;
                r_rec   <= w_rec;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd    <= i_cmd;
                        r_tidx   <= 1'b0;
                        r_pend_v <= i_cmd.has_vtx && !i_cmd.marker;
                        if (i_cmd.has_vtx && !i_cmd.marker) begin
                            r_state <= S_DIV;
                            r_phase <= 1'b0;
                            r_dcnt  <= '0;
                            r_den   <= i_geom.cols;
                            r_rem   <= w_num_t[NW-1:QW];
                            r_dq    <= w_num_t[QW-1:0];
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV: begin
                    if (r_dcnt == DCW'(QW)) begin
                        // quotient ready, start CORDIC on first quadrant residue
                        r_state <= S_CORD;
                        r_ci    <= '0;
                        r_cx    <= CORDIC_GAIN;
                        r_cy    <= '0;
                        r_cz    <= w_z0;
                        r_quad  <= w_ang[ANGLE_BITS-1:ANGLE_BITS-2];
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                        r_rem  <= w_ge ? w_sub[SEG_W-1:0] : w_t[SEG_W-1:0];
                        r_dq   <= {r_dq[QW-2:0], w_ge};
                    end
                end
                S_CORD: begin
                    if (r_ci == 5'(CORDIC_STEPS)) begin
                        if (!r_phase) begin
                            r_st    <= w_sn;
                            r_ct    <= w_cs;
                            r_phase <= 1'b1;
                            r_state <= S_DIV;
                            r_dcnt  <= '0;
                            r_den   <= i_geom.rows;
                            r_rem   <= w_num_p[NW-1:QW];
                            r_dq    <= w_num_p[QW-1:0];
                        end else begin
                            r_sp    <= w_sn;
                            r_cp    <= w_cs;
                            r_k     <= 3'd0;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_ci <= r_ci + 1'b1;
                        if (!r_cz[32]) begin
                            r_cx <= r_cx - w_ys;
                            r_cy <= r_cy + w_xs;
                            r_cz <= r_cz - w_atan;
                        end else begin
                            r_cx <= r_cx + w_ys;
                            r_cy <= r_cy - w_xs;
                            r_cz <= r_cz + w_atan;
                        end
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 3'd1;
                    case (r_k)
                        3'd0:    r_n0 <= w_sat[15:0];
                        3'd1:    r_n2 <= w_sat[15:0];
                        3'd2:    r_px <= w_sat;
                        3'd3:    r_py <= w_sat;
                        default: begin
                            r_pz    <= w_sat;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_EMIT: begin
                    if (w_free) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else if (r_pend_v) begin
                            r_pend_v <= 1'b0;
                        end else begin
                            r_tidx <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/uv_sphere_tessellator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// UV-sphere mesh generator: vertex and triangle records per grid tick.
//
//  channel | dir | handshake                  | payload
//  s       | in  | i_s_tvalid / o_s_tready    | i_s_tdata: restart
//  m       | out | o_m_tvalid / i_m_tready    | o_m_tdata, o_m_tuser, o_m_tlast
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Ticks enter a two-entry queue at one per cycle while it has room.
//  The back end takes a command while idle; for a vertex it then runs the
//  angle divider and CORDIC unit for the column angle, again for the row
//  angle, and then the shared multiplier; each record then leaves through
//  the output register. Only one command is worked on at a time.
//  Reset is synchronous; the output register stalls the back end only.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator import sphtess_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,    // [0] restart
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner_a, corner_b, corner_c
    output logic [151:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,    // [1:0] kind
    output logic         o_m_tlast,    // run_end
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [SEG_W-1:0] r_cols, r_rows;
    logic [RAD_W-1:0] r_radius;
    t_geom            w_geom;
    t_cmd             w_fcmd, w_bcmd;
    t_rec             w_rec;
    logic             w_push, w_full, w_pop, w_empty;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= 9'd32;
            r_rows   <= 9'd16;
            r_radius <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COLUMNS: r_cols   <= i_cfg_data[SEG_W-1:0];
                REG_ROWS:    r_rows   <= i_cfg_data[SEG_W-1:0];
                REG_RADIUS:  r_radius <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // clamped grid
    always_comb begin
        w_geom.radius = r_radius;
        if (r_cols < 9'd3)                  w_geom.cols = 9'd3;
        else if (32'(r_cols) > MAX_SEGMENTS) w_geom.cols = SEG_W'(MAX_SEGMENTS);
        else                                w_geom.cols = r_cols;
        if (r_rows < 9'd2)                  w_geom.rows = 9'd2;
        else if (32'(r_rows) > MAX_SEGMENTS) w_geom.rows = SEG_W'(MAX_SEGMENTS);
        else                                w_geom.rows = r_rows;
    end

    sphtess_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_valid   (i_s_tvalid),
        .i_restart (i_s_tdata[0]),
        .o_ready   (o_s_tready),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_fcmd)
    );

    sphtess_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_bcmd)
    );

    sphtess_back #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_cmd   (w_bcmd),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rec   (w_rec)
    );

    // output packing
    assign o_m_tdata = {5'b0, w_rec.corner_c, w_rec.corner_b, w_rec.corner_a,
                        w_rec.norm_z, w_rec.norm_y, w_rec.norm_x,
                        w_rec.pos_z, w_rec.pos_y, w_rec.pos_x};
    assign o_m_tuser = w_rec.kind;
    assign o_m_tlast = w_rec.run_end;

`ifndef SYNTH
    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overflow");

    // a restart tick queues nothing
    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[0]) |-> !w_push)
        else $error("restart produced a command");

    // finished marker always closes its tick
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_DONE) |-> o_m_tlast)
        else $error("marker without run end");

    // vertex normal x component stays within unit range
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_VERTEX) |->
        ($signed(o_m_tdata[66:51]) <= 16'sd16384 &&
         $signed(o_m_tdata[66:51]) >= -16'sd16384))
        else $error("normal out of range");
`endif

endmodule
